FILE: rtl/core/two_level_page_table_engine_top_assert.svh
// Assertion macros shared by the page table engine checkers.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef TWO_LEVEL_PAGE_TABLE_ENGINE_TOP_ASSERT_SVH
`define TWO_LEVEL_PAGE_TABLE_ENGINE_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define TLPT_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("page table engine assertion failed");

// antecedent implies consequent in the next cycle
`define TLPT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("page table engine assertion failed");

`endif

FILE: rtl/core/tlpt_pkg.sv
// Shared constants, codes and types of the two-level page table engine.
// No dependencies.
package tlpt_pkg;

	localparam int FRAME_LIMIT       = 16;
	localparam int ENTRIES_PER_TABLE = 1024;

	localparam int IDX_W       = $clog2(ENTRIES_PER_TABLE);
	localparam int PAGE_SHIFT  = 12;
	localparam int DIR_SHIFT   = PAGE_SHIFT + IDX_W;
	localparam int FRAME_IDX_W = $clog2(FRAME_LIMIT);
	localparam int USED_W      = $clog2(FRAME_LIMIT + 1);
	localparam int RAM_DEPTH   = FRAME_LIMIT * ENTRIES_PER_TABLE;
	localparam int RAM_AW      = FRAME_IDX_W + IDX_W;

	localparam int IN_W  = 72;
	localparam int OUT_W = 72;

	localparam logic [31:0] FRAME_BASE_RST = 32'h0010_1000;
	localparam logic [31:0] PAGE_MASK      = 32'hFFFF_F000;
	localparam logic [31:0] NOT_MAPPED     = 32'hFFFF_FFFF;
	localparam logic [31:0] ENTRY_PRESENT  = 32'h0000_0003;

	typedef enum logic [1:0] {
		OP_MAP   = 2'd0,
		OP_XLATE = 2'd1,
		OP_UNMAP = 2'd2,
		OP_FAULT = 2'd3
	} op_t;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_UNMAPPED = 2'd1;
	localparam logic [1:0] ST_NOFRAME  = 2'd2;

	typedef struct packed {
		logic              we;
		logic [RAM_AW-1:0] addr;
		logic [31:0]       wdata;
	} mem_req_t;

	typedef struct packed {
		logic [31:0] last_fault;
		logic [1:0]  status;
		logic        dirty;
		logic [31:0] phys_addr;
	} result_t;

endpackage

FILE: rtl/core/tlpt_ram.sv
// Single-port synchronous frame memory with registered read.
// Generic; no package dependency.
module tlpt_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: rtl/core/tlpt_walk.sv
// Table walk sequencer: clearing pass, directory and leaf accesses, bump allocator.
// Depends on tlpt_pkg; drives one port of the frame memory.
module tlpt_walk import tlpt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] frame_base,
	input  logic        in_valid,
	output logic        in_ready,
	input  op_t         in_op,
	input  logic [31:0] in_va,
	input  logic [31:0] in_ta,
	output logic        res_valid,
	input  logic        res_ready,
	output result_t     res,
	output mem_req_t    mem_req,
	input  logic [31:0] mem_rdata
);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_DIR   = 6'b000100,
		S_SLOT  = 6'b001000,
		S_LEAF  = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t            state_q;
	logic [RAM_AW-1:0] clr_q;
	op_t               op_q;
	logic [31:0]       va_q;
	logic [31:0]       data_q;
	logic [31:0]       pde_q;
	logic              fault_ok_q;
	logic [USED_W-1:0] used_q;
	logic [31:0]       shared_q;
	logic [31:0]       recent_q;
	logic [31:0]       phys_q;
	logic              dirty_q;
	logic [1:0]        status_q;

	logic [31:0]       alloc_pa;
	logic              can_alloc;
	logic [31:0]       rel;
	logic              in_store;
	logic [RAM_AW-1:0] slot;
	logic [RAM_AW-1:0] dir_addr;
	logic              installs;

	assign alloc_pa  = frame_base + (32'(used_q) << PAGE_SHIFT);
	assign can_alloc = used_q < USED_W'(FRAME_LIMIT);
	assign rel       = (pde_q & PAGE_MASK) - frame_base;
	assign in_store  = rel[31:PAGE_SHIFT] < (32 - PAGE_SHIFT)'(FRAME_LIMIT);
	assign slot      = {rel[PAGE_SHIFT+FRAME_IDX_W-1:PAGE_SHIFT], va_q[DIR_SHIFT-1:PAGE_SHIFT]};
	assign dir_addr  = {FRAME_IDX_W'(0), va_q[31:DIR_SHIFT]};
	assign installs  = (op_q inside {OP_MAP, OP_FAULT});

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = '{last_fault: recent_q, status: status_q, dirty: dirty_q,
			phys_addr: phys_q};

	always_comb begin
		mem_req.we    = 1'b0;
		mem_req.addr  = {FRAME_IDX_W'(0), in_va[31:DIR_SHIFT]};
		mem_req.wdata = '0;
		case (state_q)
			S_CLEAR: begin
				mem_req.we   = 1'b1;
				mem_req.addr = clr_q;
			end
			S_DIR: begin
				mem_req.addr = dir_addr;
				if (installs && fault_ok_q && mem_rdata == '0 && can_alloc) begin
					mem_req.we    = 1'b1;
					mem_req.wdata = alloc_pa | ENTRY_PRESENT;
				end
			end
			S_SLOT: begin
				mem_req.addr = slot;
				if (installs && in_store) begin
					mem_req.we    = 1'b1;
					mem_req.wdata = data_q | ENTRY_PRESENT;
				end
			end
			S_LEAF: begin
				mem_req.addr = slot;
				if (op_q == OP_UNMAP) begin
					mem_req.we    = 1'b1;
					mem_req.wdata = {mem_rdata[31:1], 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			used_q     <= USED_W'(1);
			shared_q   <= '0;
			recent_q   <= '0;
			fault_ok_q <= 1'b1;
			op_q       <= OP_MAP;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + RAM_AW'(1);
					if (clr_q == RAM_AW'(RAM_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						op_q       <= in_op;
						va_q       <= in_va;
						data_q     <= in_ta;
						fault_ok_q <= 1'b1;
						phys_q     <= '0;
						dirty_q    <= 1'b0;
						status_q   <= ST_OK;
						state_q    <= S_DIR;
						if (in_op == OP_FAULT) begin
							recent_q <= in_va;
							if (shared_q == '0) begin
								if (can_alloc) begin
									shared_q <= alloc_pa;
									data_q   <= alloc_pa;
									used_q   <= used_q + USED_W'(1);
								end else begin
									fault_ok_q <= 1'b0;
								end
							end else begin
								data_q <= shared_q;
							end
						end
					end
				end
				S_DIR: begin
					pde_q   <= mem_rdata;
					state_q <= S_SLOT;
					if (installs) begin
						if (!fault_ok_q) begin
							status_q <= ST_NOFRAME;
							state_q  <= S_DONE;
						end else if (mem_rdata == '0) begin
							if (can_alloc) begin
								pde_q  <= alloc_pa | ENTRY_PRESENT;
								used_q <= used_q + USED_W'(1);
							end else begin
								status_q <= ST_NOFRAME;
								state_q  <= S_DONE;
							end
						end
					end
				end
				S_SLOT: begin
					if (installs) begin
						status_q <= in_store ? ST_OK : ST_UNMAPPED;
						state_q  <= S_DONE;
					end else if (pde_q[0] && in_store) begin
						state_q <= S_LEAF;
					end else begin
						status_q <= ST_UNMAPPED;
						if (op_q == OP_XLATE) begin
							phys_q <= NOT_MAPPED;
						end
						state_q <= S_DONE;
					end
				end
				S_LEAF: begin
					state_q <= S_DONE;
					if (op_q == OP_XLATE) begin
						if (mem_rdata[0]) begin
							phys_q <= (mem_rdata & PAGE_MASK) | (va_q & ~PAGE_MASK);
						end else begin
							phys_q   <= NOT_MAPPED;
							status_q <= ST_UNMAPPED;
						end
					end else begin
						dirty_q <= mem_rdata[6];
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/two_level_page_table_engine_top.sv
// A result passes the directory, slot and done states and the output register; translate and
// unmap add a leaf state. Slot is skipped when frames run out, leaf when the directory entry is
// absent or outside. The walk takes the next word in idle, entered as the result moves to the
// output register. Directory read, leaf read and write-back share the one frame memory port.
// After reset a clearing pass over FRAME_LIMIT*1024 entries (16384) zeroes the frame store;
// s_axis_tready stays low for its length, configuration writes are taken throughout.
module two_level_page_table_engine_top import tlpt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// operation[1:0], virt_addr[33:2], target_addr[65:34], zero fill
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// phys_addr[31:0], dirty[32], status[34:33], last_fault[66:35], zero fill
	output logic [OUT_W-1:0] m_axis_tdata,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [31:0]      cfg_data
);

	logic [31:0] frame_base_q;
	logic        res_valid;
	logic        res_ready;
	result_t     res;
	result_t     out_q;
	logic        out_valid_q;
	mem_req_t    mem_req;
	logic [31:0] mem_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q <= FRAME_BASE_RST;
		end else if (cfg_valid) begin
			frame_base_q <= cfg_data & PAGE_MASK;
		end
	end

	tlpt_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame_base(frame_base_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (op_t'(s_axis_tdata[1:0])),
		.in_va     (s_axis_tdata[33:2]),
		.in_ta     (s_axis_tdata[65:34]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	tlpt_ram #(
		.DEPTH(RAM_DEPTH),
		.AW   (RAM_AW),
		.DW   (32)
	) u_ram (
		.clk  (clk),
		.we   (mem_req.we),
		.addr (mem_req.addr),
		.wdata(mem_req.wdata),
		.rdata(mem_rdata)
	);

	// output register: load when empty or draining
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_W - $bits(result_t))'(0), out_q};

endmodule

FILE: rtl/core/tlpt_check.sv
// Port-level checker for the page table engine, bound to the top level.
// Depends on tlpt_pkg and two_level_page_table_engine_top_assert.svh.
`include "two_level_page_table_engine_top_assert.svh"

module tlpt_check import tlpt_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata
);

	`TLPT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	`TLPT_ASSERT_SAME(a_status_code, m_axis_tvalid, m_axis_tdata[34:33] != 2'd3)
	`TLPT_ASSERT_SAME(a_dirty_ok, m_axis_tvalid && m_axis_tdata[32], m_axis_tdata[34:33] == ST_OK)
	`TLPT_ASSERT_NEXT(a_one_walk, s_axis_tvalid && s_axis_tready, !s_axis_tready && !$rose(m_axis_tvalid))

endmodule

bind two_level_page_table_engine_top tlpt_check u_check (.*);

FILE: dv/tb_two_level_page_table_engine_top.sv
// Self-checking bench for two_level_page_table_engine_top: directed walks, then random
// map/translate/unmap/fault traffic across several frame_base settings with random stalls.
// Depends on tlpt_pkg and the engine RTL only.
module tb_two_level_page_table_engine_top;
	import tlpt_pkg::*;

	typedef struct {
		op_t         op;
		logic [31:0] va;
		logic [31:0] ta;
		bit          known;
		result_t     res;
	} walk_row_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	// operation[1:0], virt_addr[33:2], target_addr[65:34], zero fill
	logic [IN_W-1:0]  s_axis_tdata;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	// phys_addr[31:0], dirty[32], status[34:33], last_fault[66:35], zero fill
	logic [OUT_W-1:0] m_axis_tdata;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [31:0]      cfg_data;

	// shadow copy of the engine state
	logic [31:0] shadow_frames [RAM_DEPTH];
	int unsigned frames_taken;
	logic [31:0] fault_frame;
	logic [31:0] last_fault_va;
	logic [31:0] base_addr;

	result_t     due_results [$];
	walk_row_t   walk_rows [$];
	int          items_sent = 0;
	int          fail_count = 0;
	int          src_calm = 0;
	bit          hold_rx = 1'b0;

	always #2 clk = ~clk;

	two_level_page_table_engine_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	function automatic int leaf_index(logic [31:0] pde, logic [9:0] lo);
		logic [31:0] rel;
		rel = (pde & PAGE_MASK) - base_addr;
		if ((rel >> PAGE_SHIFT) >= FRAME_LIMIT)
			return -1;
		return int'(rel >> PAGE_SHIFT) * ENTRIES_PER_TABLE + int'(lo);
	endfunction

	function automatic bit take_frame(output logic [31:0] fa);
		fa = 32'h0;
		if (frames_taken >= FRAME_LIMIT)
			return 1'b0;
		fa = base_addr + (32'(frames_taken) << PAGE_SHIFT);
		frames_taken++;
		return 1'b1;
	endfunction

	// Allocate a leaf table if the directory slot is empty, then write pa|3.
	function automatic logic [1:0] install_leaf(logic [31:0] va, logic [31:0] pa);
		logic [31:0] pde;
		logic [31:0] fa;
		int          slot;
		pde = shadow_frames[va[31:22]];
		if (pde == 32'h0) begin
			if (!take_frame(fa))
				return ST_NOFRAME;
			pde = fa | ENTRY_PRESENT;
			shadow_frames[va[31:22]] = pde;
		end
		slot = leaf_index(pde, va[21:12]);
		if (slot < 0)
			return ST_UNMAPPED;
		shadow_frames[slot] = pa | ENTRY_PRESENT;
		return ST_OK;
	endfunction

	function automatic result_t walk_request(op_t op, logic [31:0] va, logic [31:0] ta);
		result_t     r;
		logic [31:0] pde;
		logic [31:0] pte;
		logic [31:0] fa;
		int          slot;
		bit          ok;
		r = '0;
		pde = shadow_frames[va[31:22]];
		slot = leaf_index(pde, va[21:12]);
		case (op)
			OP_MAP: begin
				r.status = install_leaf(va, ta);
			end
			OP_XLATE: begin
				pte = (slot < 0) ? 32'h0 : shadow_frames[slot];
				if (pde[0] && pte[0]) begin
					r.phys_addr = (pte & PAGE_MASK) | {20'h0, va[11:0]};
				end else begin
					r.phys_addr = NOT_MAPPED;
					r.status = ST_UNMAPPED;
				end
			end
			OP_UNMAP: begin
				if (!pde[0] || slot < 0) begin
					r.status = ST_UNMAPPED;
				end else begin
					pte = shadow_frames[slot] & ~32'h1;
					shadow_frames[slot] = pte;
					r.dirty = pte[6];
				end
			end
			default: begin
				ok = 1'b1;
				if (fault_frame == 32'h0) begin
					if (take_frame(fa))
						fault_frame = fa;
					else
						ok = 1'b0;
				end
				last_fault_va = va;
				r.status = ok ? install_leaf(va, fault_frame) : ST_NOFRAME;
			end
		endcase
		r.last_fault = last_fault_va;
		return r;
	endfunction

	function automatic void add_row(op_t op, logic [31:0] va, logic [31:0] ta, bit known,
			logic [31:0] pa = 32'h0, bit dty = 1'b0, logic [1:0] st = ST_OK,
			logic [31:0] lf = 32'h0);
		walk_row_t row;
		row.op = op;
		row.va = va;
		row.ta = ta;
		row.known = known;
		row.res.phys_addr = pa;
		row.res.dirty = dty;
		row.res.status = st;
		row.res.last_fault = lf;
		walk_rows.push_back(row);
	endfunction

	function automatic int idle_length();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic offer_request(op_t op, logic [31:0] va, logic [31:0] ta, bit known,
			result_t fixed);
		int      gap;
		result_t predicted;
		if (src_calm > 0) begin
			src_calm--;
			gap = 0;
		end else if ($urandom_range(0, 99) < 3) begin
			src_calm = $urandom_range(20, 60);
			gap = 0;
		end else begin
			gap = idle_length();
		end
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IN_W - 66){1'b0}}, ta, va, op};
		do @(posedge clk); while (!s_axis_tready);
		predicted = walk_request(op, va, ta);
		due_results.push_back(known ? fixed : predicted);
		items_sent++;
	endtask

	// Drop the input and wait until every word has come back.
	task automatic drain_engine();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
	endtask

	task automatic set_frame_base(logic [31:0] value);
		drain_engine();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		base_addr = value & PAGE_MASK;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Most addresses land in a few directory slots and leaf slots so tables get reused.
	task automatic run_random(int count);
		logic [9:0]  dir_idx;
		logic [9:0]  leaf_idx;
		logic [31:0] va;
		logic [31:0] ta;
		int          pick;
		op_t         op;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			op = pick < 30 ? OP_MAP : pick < 65 ? OP_XLATE : pick < 85 ? OP_UNMAP : OP_FAULT;
			dir_idx = 10'($urandom_range(0, 15));
			if (dir_idx == 10'd15)
				dir_idx = 10'h3FF;
			case ($urandom_range(0, 7))
				0: leaf_idx = 10'h000;
				1: leaf_idx = 10'h001;
				2: leaf_idx = 10'h002;
				3: leaf_idx = 10'h003;
				4: leaf_idx = 10'h155;
				5: leaf_idx = 10'h2AA;
				6: leaf_idx = 10'h3FE;
				default: leaf_idx = 10'h3FF;
			endcase
			if ($urandom_range(0, 99) < 20)
				leaf_idx = 10'($urandom_range(0, 1023));
			va = {dir_idx, leaf_idx, 12'($urandom_range(0, 4095))};
			if ($urandom_range(0, 99) < 15)
				va = $urandom;
			ta = $urandom;
			// half of the targets point back into the frame store
			if ($urandom_range(0, 1) == 1)
				ta = (base_addr + (32'($urandom_range(0, FRAME_LIMIT - 1)) << PAGE_SHIFT))
					| {20'h0, ta[11:0]};
			offer_request(op, va, ta, 1'b0, '0);
		end
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		for (int i = 0; i < RAM_DEPTH; i++)
			shadow_frames[i] = 32'h0;
		frames_taken = 1;
		fault_frame = 32'h0;
		last_fault_va = 32'h0;
		base_addr = FRAME_BASE_RST;

		add_row(OP_XLATE, 32'h0000_0000, 32'h0, 1, NOT_MAPPED, 0, ST_UNMAPPED);
		add_row(OP_UNMAP, 32'hFFFF_FFFF, 32'h0, 1, 32'h0, 0, ST_UNMAPPED);
		add_row(OP_MAP,   32'h0000_0123, 32'hFFFF_FFFF, 1);
		add_row(OP_XLATE, 32'h0000_0ABC, 32'h0, 1, 32'hFFFF_FABC);
		add_row(OP_MAP,   32'hFFFF_FFFF, 32'h0000_0040, 1);
		add_row(OP_XLATE, 32'hFFFF_F000, 32'h0, 1, 32'h0000_0000);
		add_row(OP_UNMAP, 32'hFFFF_FFFF, 32'h0, 1, 32'h0, 1);
		add_row(OP_XLATE, 32'hFFFF_FFFF, 32'h0, 1, NOT_MAPPED, 0, ST_UNMAPPED);
		add_row(OP_UNMAP, 32'hFFFF_FFFF, 32'h0, 1, 32'h0, 1);
		// leaf never written, present bit cleared anyway
		add_row(OP_UNMAP, 32'h0000_1000, 32'h0, 1);
		for (int d = 1; d <= 12; d++)
			add_row(OP_MAP, 32'(d) << DIR_SHIFT, 32'h8000_0040 | (32'(d) << PAGE_SHIFT), 0);
		// shared frame takes the last slot, leaf table allocation then runs dry
		add_row(OP_FAULT, 32'h0345_6789, 32'h0, 1, 32'h0, 0, ST_NOFRAME, 32'h0345_6789);
		add_row(OP_FAULT, 32'h0000_0000, 32'h0, 1);
		add_row(OP_XLATE, 32'h0000_0ABC, 32'h0, 1, 32'h0011_0ABC);
		add_row(OP_MAP,   32'h0380_0000, 32'h0, 1, 32'h0, 0, ST_NOFRAME);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (walk_rows[i])
			offer_request(walk_rows[i].op, walk_rows[i].va, walk_rows[i].ta,
				walk_rows[i].known, walk_rows[i].res);

		set_frame_base(32'hFFFF_FFFF);
		run_random(100);
		set_frame_base(32'h0000_0000);
		run_random(100);
		// directory 1's leaf table becomes frame zero, so leaf writes hit the directory
		set_frame_base((shadow_frames[1] & PAGE_MASK) | 32'h0000_0ABC);
		run_random(350);
		set_frame_base(FRAME_BASE_RST);
		run_random(475);

		drain_engine();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && due_results.size() == 0)
			$display("** two_level_page_table_engine_top: PASSED **");
		else
			$display("** two_level_page_table_engine_top: FAILED **");
		$finish;
	end

	// Receiver: random stalls with calm stretches, forced low during a long hold.
	initial begin : result_sink
		int stall;
		int calm;
		stall = 0;
		calm = 0;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_rx) begin
				m_axis_tready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (calm > 0)
					calm--;
				else if ($urandom_range(0, 99) < 3)
					calm = $urandom_range(40, 120);
				else
					stall = idle_length();
			end
		end
	end

	// Hold the receiver off long enough for the engine to back up into its input.
	initial begin : rx_hold
		wait (items_sent >= 200);
		@(posedge clk);
		hold_rx = 1'b1;
		repeat (400) @(posedge clk);
		hold_rx = 1'b0;
	end

	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[$bits(result_t)-1:0];
			if (due_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected word: phys %h dirty %b status %0d last_fault %h",
						got.phys_addr, got.dirty, got.status, got.last_fault);
			end else begin
				want = due_results.pop_front();
				if (got.phys_addr !== want.phys_addr || got.dirty !== want.dirty ||
						got.status !== want.status || got.last_fault !== want.last_fault) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: phys %h/%h dirty %b/%b status %0d/%0d lf %h/%h",
							want.phys_addr, got.phys_addr, want.dirty, got.dirty,
							want.status, got.status, want.last_fault, got.last_fault);
				end
			end
		end
	end

	initial begin : watchdog
		#4000000;
		$display("** two_level_page_table_engine_top: FAILED **");
		$finish;
	end

endmodule

FILE: two_level_page_table_engine_top.f
+incdir+rtl/core
rtl/core/tlpt_pkg.sv
rtl/core/tlpt_ram.sv
rtl/core/tlpt_walk.sv
rtl/core/two_level_page_table_engine_top.sv
rtl/core/tlpt_check.sv
dv/tb_two_level_page_table_engine_top.sv
